FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define BCGF_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BCGF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/bcgf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcgf_pkg
// Shared types and constants of the corner gradient fill block.
// ---------------------------------------------------------------------------
package bcgf_pkg;

   localparam int NUM_CH      = 3;
   localparam int CH_W        = 8;
   localparam int COLOR_W     = 24;
   localparam int DIM_REG_W   = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CORNER_LB    = 3'd0,
      REG_CORNER_LT    = 3'd1,
      REG_CORNER_RB    = 3'd2,
      REG_CORNER_RT    = 3'd3,
      REG_FRAME_WIDTH  = 3'd4,
      REG_FRAME_HEIGHT = 3'd5
   } csr_reg_type;

   // one queued item as handed from the front end to the back end
   typedef struct packed {
      logic restart;
   } item_type;

endpackage

FILE: design/bcgf_chan_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcgf channel interfaces
// Valid/ready channels for the tick input and the pixel output.
// ---------------------------------------------------------------------------
interface bcgf_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface bcgf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bcgf_pkg::COLOR_W-1:0]    pixel;
   logic                            last_in_row;
   logic                            last_in_frame;

   modport source (output valid, output pixel, output last_in_row, output last_in_frame,
                   input ready);
   modport sink (input valid, input pixel, input last_in_row, input last_in_frame,
                 output ready);
endinterface

FILE: design/bcgf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcgf_front
// Accepts tick items and holds them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module bcgf_front (
   input  logic               clock,
   input  logic               reset,
   bcgf_req_if.sink           req_chan,
   output logic               q_valid,
   output bcgf_pkg::item_type q_item,
   input  logic               q_pop
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bcgf_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign req_chan.ready = (count_ff != CNT_W'(DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != '0);
   assign pop            = q_pop && q_valid;
   assign q_item         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].restart <= req_chan.restart;
      end
   end

endmodule

FILE: design/bcgf_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcgf_divider
// Three-lane signed divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
module bcgf_divider #(
   parameter int DIVD_W = 43,
   parameter int DIM_W  = 13
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIM_W-1:0]         divisor,
   input  logic signed [DIVD_W-1:0] dividend [bcgf_pkg::NUM_CH],
   output logic                     done,
   output logic signed [DIVD_W-1:0] quotient [bcgf_pkg::NUM_CH]
);

   localparam int NCH   = bcgf_pkg::NUM_CH;
   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIM_W-1:0]  div_ff;
   logic [DIVD_W-1:0] mag_ff [NCH];
   logic [DIVD_W-1:0] mag_in [NCH];
   logic [DIM_W-1:0]  rem_ff [NCH];
   logic [DIM_W-1:0]  rem_in [NCH];
   logic              neg_ff [NCH];
   logic [DIM_W:0]    trial  [NCH];
   logic              fits   [NCH];
   logic              busy;

   assign busy = (cnt_ff != '0);
   assign done = done_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = busy && (cnt_ff == CNT_W'(1));
      if (start) begin
         cnt_in = CNT_W'(DIVD_W);
      end else if (busy) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      for (int c = 0; c < NCH; c++) begin
         // shift the next dividend bit into the partial remainder
         trial[c] = {rem_ff[c], mag_ff[c][DIVD_W-1]};
         fits[c]  = (trial[c] >= {1'b0, div_ff});
         rem_in[c] = fits[c] ? DIM_W'(trial[c] - {1'b0, div_ff}) : DIM_W'(trial[c]);
         mag_in[c] = {mag_ff[c][DIVD_W-2:0], fits[c]};
         quotient[c] = neg_ff[c] ? DIVD_W'(-mag_ff[c]) : mag_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         for (int c = 0; c < NCH; c++) begin
            neg_ff[c] <= dividend[c][DIVD_W-1];
            mag_ff[c] <= dividend[c][DIVD_W-1] ? DIVD_W'(-dividend[c]) : dividend[c];
            rem_ff[c] <= '0;
         end
      end else if (busy) begin
         for (int c = 0; c < NCH; c++) begin
            mag_ff[c] <= mag_in[c];
            rem_ff[c] <= rem_in[c];
         end
      end
   end

endmodule

FILE: design/bcgf_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcgf_engine
// Back end: walks the frame, runs the edge and row step divisions,
// accumulates the color values and drives the pixel output register.
// ---------------------------------------------------------------------------
module bcgf_engine #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  bcgf_pkg::item_type               q_item,
   output logic                             q_pop,
   input  logic [bcgf_pkg::COLOR_W-1:0]     corner_lb,
   input  logic [bcgf_pkg::COLOR_W-1:0]     corner_lt,
   input  logic [bcgf_pkg::COLOR_W-1:0]     corner_rb,
   input  logic [bcgf_pkg::COLOR_W-1:0]     corner_rt,
   input  logic [$clog2(MAX_DIM+1)-1:0]     w_eff,
   input  logic [$clog2(MAX_DIM+1)-1:0]     h_eff,
   output logic                             div_start,
   output logic [$clog2(MAX_DIM+1)-1:0]     div_divisor,
   output logic signed [bcgf_pkg::CH_W+FRAC_BITS+$clog2(MAX_DIM+1)+1:0]
                                            div_dividend [bcgf_pkg::NUM_CH],
   input  logic                             div_done,
   input  logic signed [bcgf_pkg::CH_W+FRAC_BITS+$clog2(MAX_DIM+1)+1:0]
                                            div_quot [bcgf_pkg::NUM_CH],
   bcgf_rsp_if.source                       rsp_chan
);

   localparam int NCH      = bcgf_pkg::NUM_CH;
   localparam int CH_W     = bcgf_pkg::CH_W;
   localparam int COLOR_W  = bcgf_pkg::COLOR_W;
   localparam int DIM_W    = $clog2(MAX_DIM + 1);
   localparam int IDX_W    = $clog2(MAX_DIM);
   localparam int SCALED_W = CH_W + FRAC_BITS;
   localparam int EDGE_W   = SCALED_W + DIM_W + 1;
   localparam int DIVD_W   = EDGE_W + 1;
   localparam int ACC_W    = EDGE_W + DIM_W + 2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LDIV = 5'b00010,
      ST_RDIV = 5'b00100,
      ST_PDIV = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          row_ff, row_in;
   logic [IDX_W-1:0]          col_ff, col_in;
   logic signed [EDGE_W-1:0]  le_val_ff [NCH];
   logic signed [EDGE_W-1:0]  le_val_in [NCH];
   logic signed [EDGE_W-1:0]  re_val_ff [NCH];
   logic signed [EDGE_W-1:0]  re_val_in [NCH];
   logic signed [EDGE_W-1:0]  le_step_ff [NCH];
   logic signed [EDGE_W-1:0]  le_step_in [NCH];
   logic signed [EDGE_W-1:0]  re_step_ff [NCH];
   logic signed [EDGE_W-1:0]  re_step_in [NCH];
   logic signed [ACC_W-1:0]   px_val_ff [NCH];
   logic signed [ACC_W-1:0]   px_val_in [NCH];
   logic signed [DIVD_W-1:0]  px_step_ff [NCH];
   logic signed [DIVD_W-1:0]  px_step_in [NCH];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]        pixel_ff, pixel_in;
   logic                      lir_ff, lir_in;
   logic                      lif_ff, lif_in;

   logic [IDX_W-1:0]          row_z;
   logic [IDX_W-1:0]          col_z;
   logic                      frame_start;
   logic                      row_start;
   logic                      slot_free;
   logic                      row_end;
   logic                      frame_end;
   logic                      emit;
   logic signed [EDGE_W-1:0]  lb_s [NCH];
   logic signed [EDGE_W-1:0]  rb_s [NCH];
   logic signed [DIVD_W-1:0]  left_diff [NCH];
   logic signed [DIVD_W-1:0]  right_diff [NCH];
   logic signed [DIVD_W-1:0]  row_diff [NCH];

   function automatic logic [SCALED_W-1:0] scaled(input logic [COLOR_W-1:0] color,
                                                   input int c);
      scaled = SCALED_W'(color[CH_W*c +: CH_W]) << FRAC_BITS;
   endfunction

   // clamp an accumulator to one 8-bit channel
   function automatic logic [CH_W-1:0] chan_out(input logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1]) begin
         chan_out = '0;
      end else if (|v[ACC_W-2:FRAC_BITS+CH_W]) begin
         chan_out = '1;
      end else begin
         chan_out = v[FRAC_BITS+CH_W-1:FRAC_BITS];
      end
   endfunction

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel         = pixel_ff;
   assign rsp_chan.last_in_row   = lir_ff;
   assign rsp_chan.last_in_frame = lif_ff;

   always_comb begin
      row_z       = q_item.restart ? '0 : row_ff;
      col_z       = q_item.restart ? '0 : col_ff;
      frame_start = (row_z == '0) && (col_z == '0);
      row_start   = (col_z == '0);
      slot_free   = !rsp_valid_ff || rsp_chan.ready;
      row_end     = ((DIM_W+1)'(col_ff) + (DIM_W+1)'(1)) >= (DIM_W+1)'(w_eff);
      frame_end   = row_end &&
                    (((DIM_W+1)'(row_ff) + (DIM_W+1)'(1)) >= (DIM_W+1)'(h_eff));
      for (int c = 0; c < NCH; c++) begin
         lb_s[c]       = EDGE_W'(scaled(corner_lb, c));
         rb_s[c]       = EDGE_W'(scaled(corner_rb, c));
         left_diff[c]  = DIVD_W'(scaled(corner_lt, c)) - DIVD_W'(scaled(corner_lb, c));
         right_diff[c] = DIVD_W'(scaled(corner_rt, c)) - DIVD_W'(scaled(corner_rb, c));
         row_diff[c]   = DIVD_W'(re_val_ff[c]) - DIVD_W'(le_val_ff[c]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      le_val_in    = le_val_ff;
      re_val_in    = re_val_ff;
      le_step_in   = le_step_ff;
      re_step_in   = re_step_ff;
      px_val_in    = px_val_ff;
      px_step_in   = px_step_ff;
      pixel_in     = pixel_ff;
      lir_in       = lir_ff;
      lif_in       = lif_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      div_start    = 1'b0;
      div_divisor  = h_eff;
      div_dividend = left_diff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (row_start) begin
                  q_pop  = 1'b1;
                  row_in = row_z;
                  col_in = col_z;
                  div_start = 1'b1;
                  if (frame_start) begin
                     le_val_in = lb_s;
                     re_val_in = rb_s;
                     state_in  = ST_LDIV;
                  end else begin
                     for (int c = 0; c < NCH; c++) begin
                        px_val_in[c] = ACC_W'(le_val_ff[c]);
                     end
                     div_divisor  = w_eff;
                     div_dividend = row_diff;
                     state_in     = ST_PDIV;
                  end
               end else if (slot_free) begin
                  // mid-row item goes straight to the output register
                  q_pop = 1'b1;
                  emit  = 1'b1;
               end
            end
         end
         ST_LDIV: begin
            if (div_done) begin
               for (int c = 0; c < NCH; c++) begin
                  le_step_in[c] = EDGE_W'(div_quot[c]);
               end
               div_start    = 1'b1;
               div_dividend = right_diff;
               state_in     = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               for (int c = 0; c < NCH; c++) begin
                  re_step_in[c] = EDGE_W'(div_quot[c]);
                  px_val_in[c]  = ACC_W'(le_val_ff[c]);
               end
               div_start    = 1'b1;
               div_divisor  = w_eff;
               div_dividend = row_diff;
               state_in     = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_done) begin
               px_step_in = div_quot;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         for (int c = 0; c < NCH; c++) begin
            pixel_in[CH_W*(NCH-1-c) +: CH_W] = chan_out(px_val_ff[c]);
            px_val_in[c] = px_val_ff[c] + ACC_W'(px_step_ff[c]);
         end
         lir_in = row_end;
         lif_in = frame_end;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + IDX_W'(1);
            for (int c = 0; c < NCH; c++) begin
               le_val_in[c] = le_val_ff[c] + le_step_ff[c];
               re_val_in[c] = re_val_ff[c] + re_step_ff[c];
            end
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      le_val_ff  <= le_val_in;
      re_val_ff  <= re_val_in;
      le_step_ff <= le_step_in;
      re_step_ff <= re_step_in;
      px_val_ff  <= px_val_in;
      px_step_ff <= px_step_in;
      pixel_ff   <= pixel_in;
      lir_ff     <= lir_in;
      lif_ff     <= lif_in;
   end

endmodule

FILE: design/bilinear_corner_gradient_fill_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_corner_gradient_fill_unit
// Four-corner color gradient generator, one pixel per tick item.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one tick item per pixel; restart=1 begins a new frame at
//   row zero, column zero. rsp_chan returns one pixel item per tick, with
//   last_in_row and last_in_frame flags. csr_* writes the corner colors and
//   the frame size; write only while no item is in flight.
// Timing:
//   A mid-row tick passes from the input queue straight into the output register,
//   and mid-row ticks stream at one per cycle while rsp_chan does not stall.
//   The first pixel of a row waits for one step division, the first pixel of a
//   frame for three. Each division runs three channel lanes in parallel, one
//   quotient bit per cycle. The divider is the only multi-cycle unit.
// Reset and stall:
//   Reset empties the two-entry input queue and the output register, sets
//   both dimensions to 1, clears the corners and positions at frame start.
//   A stalled rsp_chan holds its item; the input queue keeps taking up to two
//   ticks before req_chan.ready drops.
// ---------------------------------------------------------------------------
module bilinear_corner_gradient_fill_unit #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   bcgf_req_if.sink                           req_chan,
   bcgf_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [bcgf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bcgf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NCH      = bcgf_pkg::NUM_CH;
   localparam int COLOR_W  = bcgf_pkg::COLOR_W;
   localparam int DREG_W   = bcgf_pkg::DIM_REG_W;
   localparam int DIM_W    = $clog2(MAX_DIM + 1);
   localparam int SCALED_W = bcgf_pkg::CH_W + FRAC_BITS;
   localparam int EDGE_W   = SCALED_W + DIM_W + 1;
   localparam int DIVD_W   = EDGE_W + 1;

   logic [COLOR_W-1:0]        corner_lb_ff;
   logic [COLOR_W-1:0]        corner_lt_ff;
   logic [COLOR_W-1:0]        corner_rb_ff;
   logic [COLOR_W-1:0]        corner_rt_ff;
   logic [DREG_W-1:0]         frame_width_ff;
   logic [DREG_W-1:0]         frame_height_ff;
   logic [DIM_W-1:0]          w_eff;
   logic [DIM_W-1:0]          h_eff;

   logic                      q_valid;
   bcgf_pkg::item_type        q_item;
   logic                      q_pop;
   logic                      div_start;
   logic [DIM_W-1:0]          div_divisor;
   logic signed [DIVD_W-1:0]  div_dividend [NCH];
   logic                      div_done;
   logic signed [DIVD_W-1:0]  div_quot [NCH];

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_lb_ff    <= '0;
         corner_lt_ff    <= '0;
         corner_rb_ff    <= '0;
         corner_rt_ff    <= '0;
         frame_width_ff  <= DREG_W'(1);
         frame_height_ff <= DREG_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bcgf_pkg::REG_CORNER_LB:    corner_lb_ff    <= COLOR_W'(csr_wdata);
            bcgf_pkg::REG_CORNER_LT:    corner_lt_ff    <= COLOR_W'(csr_wdata);
            bcgf_pkg::REG_CORNER_RB:    corner_rb_ff    <= COLOR_W'(csr_wdata);
            bcgf_pkg::REG_CORNER_RT:    corner_rt_ff    <= COLOR_W'(csr_wdata);
            bcgf_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= DREG_W'(csr_wdata);
            bcgf_pkg::REG_FRAME_HEIGHT: frame_height_ff <= DREG_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, oversize saturates at the maximum dimension
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_DIM)) begin
         w_eff = DIM_W'(MAX_DIM);
      end else begin
         w_eff = DIM_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_DIM)) begin
         h_eff = DIM_W'(MAX_DIM);
      end else begin
         h_eff = DIM_W'(frame_height_ff);
      end
   end

   bcgf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   bcgf_divider #(
      .DIVD_W (DIVD_W),
      .DIM_W  (DIM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quot)
   );

   bcgf_engine #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .corner_lb    (corner_lb_ff),
      .corner_lt    (corner_lt_ff),
      .corner_rb    (corner_rb_ff),
      .corner_rt    (corner_rt_ff),
      .w_eff        (w_eff),
      .h_eff        (h_eff),
      .div_start    (div_start),
      .div_divisor  (div_divisor),
      .div_dividend (div_dividend),
      .div_done     (div_done),
      .div_quot     (div_quot),
      .rsp_chan     (rsp_chan)
   );

endmodule

FILE: design/bcgf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcgf_checker
// Port-level checks of the gradient fill block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bcgf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bcgf_pkg::COLOR_W-1:0]   rsp_pixel,
   input logic                           rsp_last_in_row,
   input logic                           rsp_last_in_frame
);

   // a stalled pixel item stays valid with its pixel and last_in_frame flag unchanged
   `BCGF_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_last_in_frame), "pixel item changed while stalled")

   // end of frame is always end of a row
   `BCGF_ASSERT_RST(a_frame_ends_row, clock, reset, rsp_valid |-> (!rsp_last_in_frame || rsp_last_in_row), "last_in_frame without last_in_row")

   `BCGF_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_valid, "output valid right after reset")

   // input queue is empty after reset
   `BCGF_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_ready, "input not ready right after reset")

endmodule

bind bilinear_corner_gradient_fill_unit bcgf_checker u_bcgf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_pixel         (rsp_chan.pixel),
   .rsp_last_in_row   (rsp_chan.last_in_row),
   .rsp_last_in_frame (rsp_chan.last_in_frame)
);
